### rtl/core/pkcd_pkg.sv
`default_nettype none

package pkcd_pkg;

   // Field widths of one input word and of the configuration registers.
   localparam int ADDR_W    = 48;
   localparam int TIME_W    = 48;
   localparam int TEMP_W    = 16;
   localparam int HUM_W     = 7;
   localparam int BAT_W     = 8;
   localparam int TTHR_W    = 10;
   localparam int HTHR_W    = 7;
   localparam int BTHR_W    = 7;
   localparam int IVL_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // Operand width of the shared subtract and compare unit.
   localparam int OP_W  = TIME_W + 1;
   localparam int MAG_W = TEMP_W + 1;

   localparam int SLOTS_DEF = 48;

   // Register reset values.
   localparam logic [TTHR_W-1:0] TEMP_THR_RST = TTHR_W'(10);
   localparam logic [HTHR_W-1:0] HUM_THR_RST  = HTHR_W'(1);
   localparam logic [BTHR_W-1:0] BAT_THR_RST  = BTHR_W'(1);
   localparam logic [IVL_W-1:0]  IVL_RST      = IVL_W'(30000);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HUM_THR  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_BAT_THR  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_IVL      = CSR_IDX_W'(3);

   typedef struct packed {
      logic [ADDR_W-1:0]        address;
      logic [TIME_W-1:0]        last_time;
      logic signed [TEMP_W-1:0] temperature;
      logic [HUM_W-1:0]         humidity;
      logic signed [BAT_W-1:0]  battery;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TEMP,
      ST_HUM,
      ST_BAT,
      ST_TIME,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

### rtl/core/pkcd_ram.sv
`default_nettype none

module pkcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                    wr_data,
   input  wire logic                                rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/per_key_change_dedup_table.sv
// Change filter for sensor readings, keyed by device address.
//
// Input words arrive on the req_ channel (valid/stall); each carries a device
// address, a timestamp, temperature, humidity and battery level. For every
// accepted word exactly one result word leaves on the rsp_ channel with the
// publish flag. An unknown address claims the first free slot (slot 0 when the
// table is full) and always publishes; a known address publishes when a value
// moved by its threshold (temperature: past it) or the republish interval ended.
//
// Timing: the table is walked one slot per cycle through a single read port
// of the slot memory. A miss walks every slot before registering its result.
// A hit stops the walk at the matching slot and passes through the states
// ST_TEMP, ST_HUM, ST_BAT and ST_TIME, in which one shared subtract and
// compare unit checks temperature, humidity, battery and elapsed time in turn.
// The result is registered from ST_DONE once the output register is free.
// req_stall is high until then; the next word can be taken in the cycle after.
// The result sits in an output register; a new word can be accepted while the
// receiver stalls it, and the next finished result waits until it is taken.
// Reset frees every slot, clears rsp_valid and presets the config registers.

`default_nettype none

module per_key_change_dedup_table
   import pkcd_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [ADDR_W-1:0]           req_device_address,
   input  wire logic [TIME_W-1:0]           req_now_ms,
   input  wire logic signed [TEMP_W-1:0]    req_temperature_centi,
   input  wire logic [HUM_W-1:0]            req_humidity_pct,
   input  wire logic signed [BAT_W-1:0]     req_battery_pct,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_publish,

   input  wire logic                        csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DAT_W-1:0]        csr_wdata
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // Configuration registers.
   logic [TTHR_W-1:0] temp_thr_ff;
   logic [HTHR_W-1:0] hum_thr_ff;
   logic [BTHR_W-1:0] bat_thr_ff;
   logic [IVL_W-1:0]  ivl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_thr_ff <= TEMP_THR_RST;
         hum_thr_ff  <= HUM_THR_RST;
         bat_thr_ff  <= BAT_THR_RST;
         ivl_ff      <= IVL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TEMP_THR: temp_thr_ff <= csr_wdata[TTHR_W-1:0];
            CSR_HUM_THR:  hum_thr_ff  <= csr_wdata[HTHR_W-1:0];
            CSR_BAT_THR:  bat_thr_ff  <= csr_wdata[BTHR_W-1:0];
            CSR_IVL:      ivl_ff      <= csr_wdata[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer and control registers.
   state_type        state_ff, state_in;
   logic [CW-1:0]    issue_idx_ff, issue_idx_in;
   logic [IW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic             free_fnd_ff, free_fnd_in;
   logic [IW-1:0]    free_idx_ff, free_idx_in;
   logic [IW-1:0]    wr_idx_ff, wr_idx_in;
   logic             pub_ff, pub_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_pub_ff, rsp_pub_in;
   logic [SLOTS-1:0] used_ff, used_in;

   // Latched input word.
   logic [ADDR_W-1:0]        addr_ff;
   logic [TIME_W-1:0]        now_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [HUM_W-1:0]         hum_ff;
   logic signed [BAT_W-1:0]  bat_ff;

   // Slot memory.
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [IW-1:0]  ram_rd_addr;
   slot_entry_type ram_wr_data;
   slot_entry_type ram_rd_data;

   pkcd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic req_take;
   logic out_free;
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Slot compare during the walk: the read data belongs to cmp_idx_ff.
   logic scan_used;
   logic scan_hit;
   logic scan_last;
   assign scan_used = used_ff[cmp_idx_ff];
   assign scan_hit  = cmp_vld_ff && scan_used && (ram_rd_data.address == addr_ff);
   assign scan_last = cmp_vld_ff && (cmp_idx_ff == IW'(SLOTS - 1));

   // Shared subtract and compare unit. In magnitude mode it compares the
   // absolute difference of two narrow values; otherwise it requires a
   // non-negative difference that reaches the bound.
   logic [OP_W-1:0]  op_a, op_b, op_bound;
   logic             op_abs;
   logic             op_gate;
   logic [OP_W-1:0]  op_diff;
   logic [MAG_W-1:0] op_mag;
   logic [OP_W-1:0]  op_lhs;
   logic             op_hit;

   assign op_diff = op_a - op_b;
   assign op_mag  = op_diff[OP_W-1] ? (MAG_W'(0) - op_diff[MAG_W-1:0])
                                    : op_diff[MAG_W-1:0];
   assign op_lhs  = op_abs ? OP_W'(op_mag) : op_diff;
   assign op_hit  = op_gate && (op_lhs >= op_bound) && (op_abs || !op_diff[OP_W-1]);

   always_comb begin
      op_a     = '0;
      op_b     = '0;
      op_bound = '0;
      op_abs   = 1'b1;
      op_gate  = 1'b0;
      unique case (state_ff)
         ST_TEMP: begin
            // Strictly more than the threshold, so compare against threshold + 1.
            op_a     = OP_W'(temp_ff);
            op_b     = OP_W'(ram_rd_data.temperature);
            op_bound = OP_W'(temp_thr_ff) + OP_W'(1);
            op_gate  = 1'b1;
         end
         ST_HUM: begin
            op_a     = OP_W'(hum_ff);
            op_b     = OP_W'(ram_rd_data.humidity);
            op_bound = OP_W'(hum_thr_ff);
            op_gate  = 1'b1;
         end
         ST_BAT: begin
            // A negative battery value means no reading, so the test is skipped.
            op_a     = OP_W'(bat_ff);
            op_b     = OP_W'(ram_rd_data.battery);
            op_bound = OP_W'(bat_thr_ff);
            op_gate  = !bat_ff[BAT_W-1];
         end
         ST_TIME: begin
            op_a     = {1'b0, now_ff};
            op_b     = {1'b0, ram_rd_data.last_time};
            op_bound = OP_W'(ivl_ff);
            op_abs   = 1'b0;
            op_gate  = 1'b1;
         end
         default: ;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_take) state_in = ST_SCAN;
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_TEMP;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end
         end
         ST_TEMP: state_in = ST_HUM;
         ST_HUM:  state_in = ST_BAT;
         ST_BAT:  state_in = ST_TIME;
         ST_TIME: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and control outputs.
   always_comb begin
      issue_idx_in = issue_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = cmp_vld_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      wr_idx_in    = wr_idx_ff;
      pub_in       = pub_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pub_in   = rsp_pub_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = issue_idx_ff[IW-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_data  = '{address: addr_ff, last_time: now_ff, temperature: temp_ff,
                       humidity: hum_ff, battery: bat_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               issue_idx_in = '0;
               cmp_vld_in   = 1'b0;
               free_fnd_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               // Hold the read data: it is the matching entry for the checks.
               wr_idx_in  = cmp_idx_ff;
               pub_in     = 1'b0;
               cmp_vld_in = 1'b0;
            end else begin
               if (cmp_vld_ff && !scan_used && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (scan_last) begin
                  // No match anywhere: first free slot, else slot 0.
                  pub_in = 1'b1;
                  if (free_fnd_ff) begin
                     wr_idx_in = free_idx_ff;
                  end else if (!scan_used) begin
                     wr_idx_in = cmp_idx_ff;
                  end else begin
                     wr_idx_in = '0;
                  end
                  cmp_vld_in = 1'b0;
               end else if (issue_idx_ff < CW'(SLOTS)) begin
                  ram_rd_en    = 1'b1;
                  cmp_vld_in   = 1'b1;
                  cmp_idx_in   = issue_idx_ff[IW-1:0];
                  issue_idx_in = issue_idx_ff + CW'(1);
               end else begin
                  cmp_vld_in = 1'b0;
               end
            end
         end
         ST_TEMP, ST_HUM, ST_BAT, ST_TIME: begin
            pub_in = pub_ff || op_hit;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pub_in   = pub_ff;
               if (pub_ff) begin
                  ram_wr_en          = 1'b1;
                  used_in[wr_idx_ff] = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         free_fnd_ff  <= 1'b0;
         pub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         free_fnd_ff  <= free_fnd_in;
         pub_ff       <= pub_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      free_idx_ff  <= free_idx_in;
      wr_idx_ff    <= wr_idx_in;
      rsp_pub_ff   <= rsp_pub_in;
      if (req_take) begin
         addr_ff <= req_device_address;
         now_ff  <= req_now_ms;
         temp_ff <= req_temperature_centi;
         hum_ff  <= req_humidity_pct;
         bat_ff  <= req_battery_pct;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_publish = rsp_pub_ff;

endmodule

`default_nettype wire

### bench/tb.sv
`default_nettype none

module tb;
   import pkcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = SLOTS_DEF;
   localparam int POOL  = 64;

   // One sensor reading as it travels on the request channel.
   typedef struct packed {
      logic [ADDR_W-1:0]        address;
      logic [TIME_W-1:0]        now_ms;
      logic signed [TEMP_W-1:0] temperature;
      logic [HUM_W-1:0]         humidity;
      logic signed [BAT_W-1:0]  battery;
   } reading_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [ADDR_W-1:0]        req_device_address = '0;
   logic [TIME_W-1:0]        req_now_ms = '0;
   logic signed [TEMP_W-1:0] req_temperature_centi = '0;
   logic [HUM_W-1:0]         req_humidity_pct = '0;
   logic signed [BAT_W-1:0]  req_battery_pct = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_publish;

   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata = '0;

   per_key_change_dedup_table #(
      .SLOTS(SLOTS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_device_address    (req_device_address),
      .req_now_ms            (req_now_ms),
      .req_temperature_centi (req_temperature_centi),
      .req_humidity_pct      (req_humidity_pct),
      .req_battery_pct       (req_battery_pct),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_publish           (rsp_publish),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the threshold registers, loaded with the reset values and
   // updated whenever the bench writes the configuration port.
   logic [TTHR_W-1:0] thr_temp = TEMP_THR_RST;
   logic [HTHR_W-1:0] thr_hum  = HUM_THR_RST;
   logic [BTHR_W-1:0] thr_bat  = BAT_THR_RST;
   logic [IVL_W-1:0]  thr_ivl  = IVL_RST;

   // Shadow copy of the slot table. Only the used flags need a reset value,
   // the other fields are never read before the slot is claimed.
   logic                     tab_used [SLOTS];
   logic [ADDR_W-1:0]        tab_address [SLOTS];
   logic [TIME_W-1:0]        tab_time [SLOTS];
   logic signed [TEMP_W-1:0] tab_temp [SLOTS];
   logic [HUM_W-1:0]         tab_hum [SLOTS];
   logic signed [BAT_W-1:0]  tab_bat [SLOTS];

   reading_type reading_q [$];   // readings waiting for the driver
   logic        publish_q [$];   // predicted publish flags, oldest first
   int          error_count = 0;

   // Stimulus helpers: a pool of device addresses and, per address, the last
   // values sent, so that most readings are small moves around those values.
   logic [ADDR_W-1:0]        pool_addr [POOL];
   logic signed [TEMP_W-1:0] pool_temp [POOL];
   logic [HUM_W-1:0]         pool_hum [POOL];
   logic signed [BAT_W-1:0]  pool_bat [POOL];
   logic [TIME_W-1:0]        time_base = '0;

   function automatic void store_slot(int k, reading_type r);
      tab_used[k]    = 1'b1;
      tab_address[k] = r.address;
      tab_time[k]    = r.now_ms;
      tab_temp[k]    = r.temperature;
      tab_hum[k]     = r.humidity;
      tab_bat[k]     = r.battery;
   endfunction

   // Works out the publish flag of one reading and updates the shadow table
   // the same way the block does.
   function automatic logic predict_publish(reading_type r);
      int   hit;
      int   vacant;
      int   i;
      int   dtemp;
      int   dhum;
      int   dbat;
      logic changed;
      logic elapsed;
      hit = -1;
      vacant = -1;
      for (i = 0; i < SLOTS; i++) begin
         if (hit < 0) begin
            if (tab_used[i] && tab_address[i] == r.address) begin
               hit = i;
            end else if (!tab_used[i] && vacant < 0) begin
               vacant = i;
            end
         end
      end
      // An unknown address takes the first free slot, or slot 0 when the
      // table is full, and is always forwarded.
      if (hit < 0) begin
         store_slot((vacant >= 0) ? vacant : 0, r);
         return 1'b1;
      end
      dtemp = int'(r.temperature) - int'(tab_temp[hit]);
      dhum  = int'(r.humidity) - int'(tab_hum[hit]);
      dbat  = int'(r.battery) - int'(tab_bat[hit]);
      if (dtemp < 0) dtemp = -dtemp;
      if (dhum < 0) dhum = -dhum;
      if (dbat < 0) dbat = -dbat;
      // The temperature must move strictly past its threshold, humidity and
      // battery only have to reach theirs. A negative battery value means no
      // reading, so its test is skipped.
      changed = (dtemp > int'(thr_temp)) || (dhum >= int'(thr_hum)) ||
                (!r.battery[BAT_W-1] && dbat >= int'(thr_bat));
      // A timestamp below the stored one never counts as an elapsed interval.
      elapsed = (r.now_ms >= tab_time[hit]) &&
                ((r.now_ms - tab_time[hit]) >= TIME_W'(thr_ivl));
      if (changed || elapsed) begin
         store_slot(hit, r);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Number of cycles a side waits before its next word. In a calm stretch
   // the side never waits, so back-to-back traffic is covered too.
   function automatic int draw_wait(bit calm);
      return calm ? 0 : int'($urandom_range(0, 9));
   endfunction

   // Request driver. A new word is presented once the previous one has been
   // accepted and the drawn gap has run out; the prediction is made at the
   // edge where the block takes the word.
   reading_type req_word;
   int          req_gap = 0;
   bit          req_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            publish_q.push_back(predict_publish(req_word));
            req_gap = draw_wait(req_calm);
            if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (reading_q.size() > 0) begin
               req_word = reading_q.pop_front();
               req_valid             <= 1'b1;
               req_device_address    <= req_word.address;
               req_now_ms            <= req_word.now_ms;
               req_temperature_centi <= req_word.temperature;
               req_humidity_pct      <= req_word.humidity;
               req_battery_pct       <= req_word.battery;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Each accepted result word is checked against the oldest
   // prediction, then the receiver stalls for a freshly drawn number of cycles.
   int   rsp_hold = 0;
   bit   rsp_calm = 1'b0;
   logic rsp_expected;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (publish_q.size() == 0) begin
               $error("publish: no result expected, got %0b", rsp_publish);
               error_count++;
            end else begin
               rsp_expected = publish_q.pop_front();
               if (rsp_publish !== rsp_expected) begin
                  $error("publish: expected %0b, got %0b", rsp_expected, rsp_publish);
                  error_count++;
               end
            end
            rsp_hold = draw_wait(rsp_calm);
            if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_reading(input logic [ADDR_W-1:0] address,
                              input logic [TIME_W-1:0] now_ms,
                              input int temperature, input int humidity,
                              input int battery);
      reading_type r;
      r.address     = address;
      r.now_ms      = now_ms;
      r.temperature = TEMP_W'(temperature);
      r.humidity    = HUM_W'(humidity);
      r.battery     = BAT_W'(battery);
      reading_q.push_back(r);
   endtask

   // Waits until every queued word has been taken and every result has come
   // back, then lets a few more cycles pass so the block is surely idle.
   task automatic wait_drained();
      do @(negedge clock);
      while (reading_q.size() != 0 || req_valid || publish_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] index,
                          input logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   // Writes all four registers on consecutive edges; only called while the
   // block is idle, so the shadow copy can follow right after.
   task automatic apply_config(input int temp_thr, input int hum_thr,
                               input int bat_thr, input logic [IVL_W-1:0] ivl);
      csr_put(CSR_TEMP_THR, CSR_DAT_W'(temp_thr));
      csr_put(CSR_HUM_THR, CSR_DAT_W'(hum_thr));
      csr_put(CSR_BAT_THR, CSR_DAT_W'(bat_thr));
      csr_put(CSR_IVL, ivl);
      @(posedge clock);
      csr_we   <= 1'b0;
      thr_temp = TTHR_W'(temp_thr);
      thr_hum  = HTHR_W'(hum_thr);
      thr_bat  = BTHR_W'(bat_thr);
      thr_ivl  = ivl;
   endtask

   // Builds one random reading. Most are plausible updates of an address from
   // the pool: time moves forward and values move by amounts around the
   // current thresholds. The rest is noise with every field drawn at random.
   function automatic reading_type make_reading(int pool_n);
      reading_type r;
      int          k;
      int          span;
      k = $urandom_range(0, pool_n - 1);
      if ($urandom_range(0, 99) < 15) begin
         r.address = ($urandom_range(0, 1) == 0) ? pool_addr[k] :
                     {16'($urandom), 32'($urandom)};
         r.now_ms = ($urandom_range(0, 3) == 0) ? {16'($urandom), 32'($urandom)} :
                    time_base - TIME_W'($urandom_range(0, 5000));
         r.temperature = TEMP_W'($urandom);
         r.humidity    = HUM_W'($urandom);
         r.battery     = BAT_W'($urandom);
         return r;
      end
      case ($urandom_range(0, 4))
         0:       time_base += TIME_W'($urandom_range(0, 50));
         1:       time_base += TIME_W'($urandom_range(0, 40000));
         2:       time_base += TIME_W'(thr_ivl);
         default: ;
      endcase
      r.address = pool_addr[k];
      r.now_ms  = time_base;
      span = int'(thr_temp) + 2;
      r.temperature = ($urandom_range(0, 2) == 0) ? pool_temp[k] :
                      TEMP_W'(int'(pool_temp[k]) + int'($urandom_range(0, 2 * span)) - span);
      span = int'(thr_hum) + 1;
      r.humidity = ($urandom_range(0, 2) == 0) ? pool_hum[k] :
                   HUM_W'(int'(pool_hum[k]) + int'($urandom_range(0, 2 * span)) - span);
      span = int'(thr_bat) + 1;
      if ($urandom_range(0, 4) == 0) begin
         r.battery = -BAT_W'(1);
      end else begin
         r.battery = ($urandom_range(0, 2) == 0) ? pool_bat[k] :
                     BAT_W'(int'(pool_bat[k]) + int'($urandom_range(0, 2 * span)) - span);
      end
      pool_temp[k] = r.temperature;
      pool_hum[k]  = r.humidity;
      pool_bat[k]  = r.battery;
      return r;
   endfunction

   task automatic random_phase(input int pool_n, input int count);
      int i;
      for (i = 0; i < count; i++) reading_q.push_back(make_reading(pool_n));
      wait_drained();
   endtask

   localparam logic [ADDR_W-1:0] ADDR_LO = '0;
   localparam logic [ADDR_W-1:0] ADDR_HI = '1;
   localparam logic [TIME_W-1:0] TIME_HI = '1;

   initial begin
      int i;
      for (i = 0; i < SLOTS; i++) tab_used[i] = 1'b0;
      pool_addr[0] = ADDR_LO;
      pool_addr[1] = ADDR_HI;
      for (i = 0; i < POOL; i++) begin
         if (i > 1) pool_addr[i] = {16'($urandom), 32'($urandom)};
         pool_temp[i] = TEMP_W'($urandom_range(0, 4000));
         pool_hum[i]  = HUM_W'($urandom_range(0, 100));
         pool_bat[i]  = BAT_W'($urandom_range(0, 100));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset thresholds. The temperature steps check
      // that a move of exactly the threshold is held back and one more is
      // forwarded; the interval is hit one short and then exactly; a time
      // that runs backwards must not count as elapsed.
      add_reading(ADDR_LO, 0, -32768, 0, -1);
      add_reading(ADDR_LO, 1, -32758, 0, -1);
      add_reading(ADDR_LO, 2, -32757, 0, -1);
      add_reading(ADDR_HI, 3, 32767, 127, -128);
      add_reading(ADDR_HI, 4, 32767, 127, 127);
      add_reading(ADDR_HI, 5, 32767, 127, 127);
      add_reading(ADDR_HI, 30003, 32767, 127, 127);
      add_reading(ADDR_HI, 30004, 32767, 127, 127);
      add_reading(ADDR_HI, 10, 32767, 127, 127);
      // A missing battery value is still stored when the slot is rewritten,
      // so the next present value is compared against it.
      add_reading(ADDR_HI, 11, 32767, 126, -1);
      add_reading(ADDR_HI, 12, 32767, 126, 0);
      add_reading(ADDR_LO, TIME_HI, -32757, 0, -1);
      add_reading(ADDR_LO, 0, -32757, 0, -1);
      wait_drained();

      // A zero battery threshold forwards every reading that carries a
      // battery value; without one the reading is held back.
      apply_config(0, 100, 0, '1);
      add_reading(ADDR_HI, 20, 32767, 126, 0);
      add_reading(ADDR_HI, 21, 32767, 126, -1);
      add_reading(ADDR_HI, 22, 32766, 126, -1);
      add_reading(ADDR_LO, 1, -32757, 0, -1);
      wait_drained();

      // A zero humidity threshold forwards every reading of a known address.
      apply_config(1023, 0, 127, '0);
      add_reading(ADDR_HI, 22, 32766, 126, -1);
      add_reading(ADDR_LO, 5, -32757, 0, -1);
      add_reading(ADDR_LO, 5, -32757, 0, 127);
      wait_drained();

      // Random part. The early phases use few addresses so the table fills
      // slowly; the later ones use more addresses than there are slots, so
      // slot 0 keeps being overwritten once the table is full.
      apply_config(10, 1, 1, 30000);
      random_phase(8, 100);
      apply_config(0, 0, 0, '0);
      random_phase(12, 100);
      apply_config(1023, 127, 127, '1);
      random_phase(20, 100);
      apply_config(1000, 100, 100, 1);
      random_phase(POOL, 100);
      apply_config($urandom_range(0, 1023), $urandom_range(0, 127),
                   $urandom_range(0, 127), $urandom);
      random_phase(POOL, 100);
      apply_config(50, 5, 5, 5000);
      random_phase(POOL, 100);

      // Give any stray result time to show up before the verdict.
      repeat (80) @(posedge clock);
      if (publish_q.size() != 0) begin
         $error("publish: %0d results never arrived", publish_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run of this stimulus.
   initial begin
      #(10_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

### per_key_change_dedup_table.f
rtl/core/pkcd_pkg.sv
rtl/core/pkcd_ram.sv
rtl/core/per_key_change_dedup_table.sv
bench/tb.sv
